// ===== design/dhf_pkg.sv =====
`default_nettype none
package dhf_pkg;

  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 4096;
  localparam int PixW       = 8;
  localparam int WidthRegW  = 12;
  localparam int HeightRegW = 13;

  localparam int ColW    = $clog2(MaxWidth);
  localparam int WidthW  = $clog2(MaxWidth + 1);
  localparam int PendW   = $clog2(MaxWidth + 2);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int HeightW = $clog2(MaxHeight + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageHeight = CfgIdxW'(1);

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(870);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(64);

  localparam int NumTaps    = 8;
  localparam int SumW       = PixW + $clog2(NumTaps);
  localparam int CntW       = $clog2(NumTaps + 1);
  localparam int RecipShift = 14;
  localparam int RecipW     = 15;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StGather,
    StDiv
  } state_e;

  typedef struct packed {
    logic            emit;
    logic            pixel;
    logic            tail;
    logic [ColW-1:0] col;
    logic            has_left;
    logic            has_right;
    logic            has_below;
    logic            has_above;
    logic            last;
  } job_t;

  // ceil(2^RecipShift / cnt), exact floor quotient for sums below 2^SumW
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      CntW'(1): r = RecipW'(16384);
      CntW'(2): r = RecipW'(8192);
      CntW'(3): r = RecipW'(5462);
      CntW'(4): r = RecipW'(4096);
      CntW'(5): r = RecipW'(3277);
      CntW'(6): r = RecipW'(2731);
      CntW'(7): r = RecipW'(2341);
      CntW'(8): r = RecipW'(2048);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/dhf_if.sv =====
`default_nettype none
interface dhf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [dhf_pkg::PixW-1:0]  pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface dhf_out_if;
  logic                      valid;
  logic                      ready;
  logic [dhf_pkg::PixW-1:0]  pixel_out;
  logic                      was_filled;
  logic                      last_of_frame;

  modport source (output valid, output pixel_out, output was_filled, output last_of_frame,
                  input ready);
  modport sink   (input valid, input pixel_out, input was_filled, input last_of_frame,
                  output ready);
endinterface

interface dhf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dhf_pkg::CfgIdxW-1:0]   index;
  logic [dhf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/dhf_ram.sv =====
`default_nettype none
module dhf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/depth_hole_fill_3x3.sv =====
// An item with a result passes the read, gather and divide states to the output register; the
// divide state holds while the output stalls. A pixel with no result passes only the read state,
// and a flush that releases nothing stays in idle. The pace is set by the two reads of the
// filled-row store through its single read port and the reciprocal multiply stage.
// Reset: asynchronous, active low; clears position, pending count and holds, loads the
// register defaults; the two line stores are not cleared.
`default_nettype none
module depth_hole_fill_3x3 (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhf_cfg_if.sink   cfg_i,
  dhf_in_if.sink    px_i,
  dhf_out_if.source px_o
);

  localparam int PW   = dhf_pkg::PixW;
  localparam int ProdW = dhf_pkg::SumW + dhf_pkg::RecipW;

  dhf_pkg::state_e state_q, state_d;

  logic [dhf_pkg::WidthRegW-1:0]  width_reg_q;
  logic [dhf_pkg::HeightRegW-1:0] height_reg_q;
  logic [dhf_pkg::WidthW-1:0]     w_eff;
  logic [dhf_pkg::HeightW-1:0]    h_eff;

  logic [dhf_pkg::RowW-1:0]  ri_q;
  logic [dhf_pkg::ColW-1:0]  ci_q;
  logic [dhf_pkg::PendW-1:0] pend_q;
  logic [PW-1:0] orig_hold_q, corner_q, last_res_q, prev1_q, prev2_q;

  dhf_pkg::job_t job_q, job_new;
  logic [PW-1:0] pix_q, centre_q, bl_q, bc_q, m0_q, u0_q;
  logic [dhf_pkg::SumW-1:0] sum_q, sum_d;
  logic [dhf_pkg::CntW-1:0] cnt_q, cnt_d;

  logic          out_valid_q;
  logic [PW-1:0] out_pix_q;
  logic          out_filled_q, out_last_q;

  logic in_fire, cfg_fire, out_load, frame_done, pend_full;
  logic w_ge2, h_ge2, h_ge3, ci_wrap, ri_wrap;
  logic [dhf_pkg::PendW-1:0] w_plus1, pend_base;
  logic [dhf_pkg::ColW-1:0]  w_last;

  logic                     u_we, m_we;
  logic [dhf_pkg::ColW-1:0] u_raddr, m_raddr;
  logic [PW-1:0]            u_rdata, m_rdata, result;
  logic                     filled;
  logic [ProdW-1:0]         prod;
  logic [PW-1:0]            taps [dhf_pkg::NumTaps];

  always_comb begin
    if (width_reg_q == '0) begin
      w_eff = dhf_pkg::WidthW'(1);
    end else if (int'(width_reg_q) > dhf_pkg::MaxWidth) begin
      w_eff = dhf_pkg::WidthW'(dhf_pkg::MaxWidth);
    end else begin
      w_eff = dhf_pkg::WidthW'(width_reg_q);
    end
    if (height_reg_q == '0) begin
      h_eff = dhf_pkg::HeightW'(1);
    end else if (int'(height_reg_q) > dhf_pkg::MaxHeight) begin
      h_eff = dhf_pkg::HeightW'(dhf_pkg::MaxHeight);
    end else begin
      h_eff = dhf_pkg::HeightW'(height_reg_q);
    end
  end

  assign in_fire  = px_i.valid && px_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign px_i.ready  = (state_q == dhf_pkg::StIdle);
  assign cfg_i.ready = 1'b1;

  assign w_plus1    = dhf_pkg::PendW'(w_eff) + dhf_pkg::PendW'(1);
  assign pend_full  = (pend_q == w_plus1);
  assign w_last     = dhf_pkg::ColW'(w_eff - dhf_pkg::WidthW'(1));
  assign w_ge2      = (w_eff >= dhf_pkg::WidthW'(2));
  assign h_ge2      = (h_eff >= dhf_pkg::HeightW'(2));
  assign h_ge3      = (h_eff >= dhf_pkg::HeightW'(3));
  assign frame_done = (ri_q == '0) && (ci_q == '0) && (pend_q != '0);
  assign ci_wrap    = (dhf_pkg::WidthW'(ci_q) + dhf_pkg::WidthW'(1)) == w_eff;
  assign ri_wrap    = (dhf_pkg::HeightW'(ri_q) + dhf_pkg::HeightW'(1)) == h_eff;
  assign pend_base  = frame_done ? '0 : pend_q;

  always_comb begin
    job_new = '0;
    if (!px_i.mode) begin
      job_new.pixel     = 1'b1;
      job_new.emit      = !frame_done && pend_full;
      job_new.has_below = 1'b1;
      if (ci_q != '0) begin
        job_new.col       = ci_q - dhf_pkg::ColW'(1);
        job_new.has_left  = (ci_q >= dhf_pkg::ColW'(2));
        job_new.has_right = 1'b1;
        job_new.has_above = (ri_q >= dhf_pkg::RowW'(2));
      end else begin
        job_new.col       = w_last;
        job_new.has_left  = w_ge2;
        job_new.has_above = (ri_q >= dhf_pkg::RowW'(3));
      end
    end else begin
      job_new.emit = frame_done;
      if (pend_full) begin
        job_new.col       = w_last;
        job_new.has_left  = w_ge2;
        job_new.has_below = 1'b1;
        job_new.has_above = h_ge3;
      end else begin
        job_new.tail      = 1'b1;
        job_new.col       = dhf_pkg::ColW'(dhf_pkg::PendW'(w_eff) - pend_q);
        job_new.has_left  = (pend_q != dhf_pkg::PendW'(w_eff));
        job_new.has_right = (pend_q > dhf_pkg::PendW'(1));
        job_new.has_above = h_ge2;
        job_new.last      = (pend_q == dhf_pkg::PendW'(1));
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhf_pkg::StIdle: begin
        if (in_fire && (!px_i.mode || frame_done)) begin
          state_d = dhf_pkg::StRead;
        end
      end
      dhf_pkg::StRead:   state_d = job_q.emit ? dhf_pkg::StGather : dhf_pkg::StIdle;
      dhf_pkg::StGather: state_d = dhf_pkg::StDiv;
      dhf_pkg::StDiv: begin
        if (out_load) begin
          state_d = dhf_pkg::StIdle;
        end
      end
    endcase
  end

  always_comb begin
    out_load = (state_q == dhf_pkg::StDiv) && (!out_valid_q || px_o.ready);
    u_we     = out_load;
    m_we     = in_fire && !px_i.mode;
    if (state_q == dhf_pkg::StRead) begin
      u_raddr = job_q.col + dhf_pkg::ColW'(1);
      m_raddr = job_q.col + dhf_pkg::ColW'(1);
    end else begin
      u_raddr = job_new.col;
      m_raddr = px_i.mode ? job_new.col : ci_q;
    end
  end

  dhf_ram #(.Width(PW), .Depth(dhf_pkg::MaxWidth)) u_filled_row (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (job_q.col),
    .wdata_i (result),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  dhf_ram #(.Width(PW), .Depth(dhf_pkg::MaxWidth)) u_orig_row (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (ci_q),
    .wdata_i (px_i.pixel_in),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  always_comb begin
    taps[0] = (job_q.has_above && job_q.has_left)  ? corner_q : '0;
    taps[1] = job_q.has_above                      ? u0_q : '0;
    taps[2] = (job_q.has_above && job_q.has_right) ? u_rdata : '0;
    taps[3] = job_q.has_left                       ? last_res_q : '0;
    taps[4] = job_q.has_right ? (job_q.tail ? m_rdata : m0_q) : '0;
    taps[5] = (job_q.has_below && job_q.has_left)  ? bl_q : '0;
    taps[6] = job_q.has_below                      ? bc_q : '0;
    taps[7] = (job_q.has_below && job_q.has_right) ? pix_q : '0;
    sum_d = '0;
    cnt_d = '0;
    for (int k = 0; k < dhf_pkg::NumTaps; k++) begin
      sum_d = sum_d + dhf_pkg::SumW'(taps[k]);
      if (taps[k] != '0) begin
        cnt_d = cnt_d + dhf_pkg::CntW'(1);
      end
    end
  end

  always_comb begin
    prod   = ProdW'(sum_q) * ProdW'(dhf_pkg::recip(cnt_q));
    filled = (centre_q == '0) && (cnt_q != '0);
    result = filled ? prod[dhf_pkg::RecipShift +: PW] : centre_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dhf_pkg::StIdle;
      width_reg_q  <= dhf_pkg::WidthReset;
      height_reg_q <= dhf_pkg::HeightReset;
      ri_q         <= '0;
      ci_q         <= '0;
      pend_q       <= '0;
      orig_hold_q  <= '0;
      corner_q     <= '0;
      last_res_q   <= '0;
      prev1_q      <= '0;
      prev2_q      <= '0;
      job_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_fire) begin
        job_q <= job_new;
        if (!px_i.mode) begin
          prev2_q <= prev1_q;
          prev1_q <= px_i.pixel_in;
          pend_q  <= job_new.emit ? pend_base : pend_base + dhf_pkg::PendW'(1);
          if (ci_wrap) begin
            ci_q <= '0;
            ri_q <= ri_wrap ? '0 : ri_q + dhf_pkg::RowW'(1);
          end else begin
            ci_q <= ci_q + dhf_pkg::ColW'(1);
          end
        end else if (frame_done) begin
          pend_q <= pend_q - dhf_pkg::PendW'(1);
        end
      end

      if (state_q == dhf_pkg::StRead && job_q.pixel) begin
        orig_hold_q <= m_rdata;
      end

      if (out_load) begin
        corner_q   <= u0_q;
        last_res_q <= result;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (px_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_fire) begin
        if (cfg_i.index == dhf_pkg::RegImageWidth) begin
          width_reg_q <= cfg_i.data[dhf_pkg::WidthRegW-1:0];
        end
        if (cfg_i.index == dhf_pkg::RegImageWidth || cfg_i.index == dhf_pkg::RegImageHeight) begin
          ri_q        <= '0;
          ci_q        <= '0;
          pend_q      <= '0;
          orig_hold_q <= '0;
          corner_q    <= '0;
        end
        if (cfg_i.index == dhf_pkg::RegImageHeight) begin
          height_reg_q <= cfg_i.data[dhf_pkg::HeightRegW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q    <= px_i.pixel_in;
      centre_q <= orig_hold_q;
      bl_q     <= prev2_q;
      bc_q     <= prev1_q;
    end
    if (state_q == dhf_pkg::StRead) begin
      u0_q <= u_rdata;
      m0_q <= m_rdata;
      if (job_q.tail) begin
        centre_q <= m_rdata;
      end
    end
    if (state_q == dhf_pkg::StGather) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (out_load) begin
      out_pix_q    <= result;
      out_filled_q <= filled;
      out_last_q   <= job_q.last;
    end
  end

  assign px_o.valid         = out_valid_q;
  assign px_o.pixel_out     = out_pix_q;
  assign px_o.was_filled    = out_filled_q;
  assign px_o.last_of_frame = out_last_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= w_plus1)
    else $error("pending count beyond one row plus one");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dhf_pkg::WidthW'(ci_q) < w_eff)
    else $error("input column outside the row");

  a_wb_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_we |=> out_valid_q)
    else $error("filled-row write without a result item");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dhf_pkg::StDiv && out_valid_q && !px_o.ready) |=>
      state_q == dhf_pkg::StDiv)
    else $error("result stage left while output stalled");
`endif

endmodule
`default_nettype wire
